[hdl/assert_macros.svh]
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("postfix evaluator check failed");

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("postfix evaluator check failed");

`endif

[hdl/pse_pkg.sv]
// types, codes and microprogram of the postfix evaluator
`timescale 1ns / 1ps

package pse_pkg;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4,
    OP_MOD    = 3'd5,
    OP_POW    = 3'd6,
    OP_FINISH = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_UNDER   = 2'd1,
    ERR_OVER    = 2'd2,
    ERR_DIVZERO = 2'd3
  } err_t;

  // datapath micro-operations
  typedef enum logic [4:0] {
    U_NOP,
    U_FETCH,
    U_EMIT,
    U_PUSH,
    U_FINISH,
    U_LOADXY,
    U_ADD,
    U_SUB,
    U_MUL,
    U_DIV_SETUP,
    U_DIV_STEP,
    U_DIV_FIN,
    U_POW_SETUP,
    U_POW_MUL,
    U_POW_SQ,
    U_WB,
    U_ERR_UNDER,
    U_ERR_OVER,
    U_ERR_DZ
  } uop_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NOACC,
    C_OUTBUSY,
    C_DISPATCH,
    C_FULL,
    C_EMPTY,
    C_LT2,
    C_YZERO,
    C_MORE,
    C_YNEG
  } cond_t;

  typedef logic [4:0] upc_t;

  typedef struct packed {
    uop_t  uop;
    cond_t cond;
    upc_t  target;
  } ucode_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic lt2;
    logic yzero;
    logic more;
    logic yneg;
  } flags_t;

  localparam upc_t A_EMIT     = 5'd0;
  localparam upc_t A_FETCH    = 5'd1;
  localparam upc_t A_DECODE   = 5'd2;
  localparam upc_t A_PUSH     = 5'd3;
  localparam upc_t A_PUSH1    = 5'd4;
  localparam upc_t A_FIN      = 5'd5;
  localparam upc_t A_FIN1     = 5'd6;
  localparam upc_t A_ADD      = 5'd7;
  localparam upc_t A_ADD1     = 5'd8;
  localparam upc_t A_SUB      = 5'd9;
  localparam upc_t A_SUB1     = 5'd10;
  localparam upc_t A_MUL      = 5'd11;
  localparam upc_t A_MUL1     = 5'd12;
  localparam upc_t A_DIV      = 5'd13;
  localparam upc_t A_DIV_SET  = 5'd14;
  localparam upc_t A_DIV_LOOP = 5'd15;
  localparam upc_t A_DIV_FIN  = 5'd16;
  localparam upc_t A_POW      = 5'd17;
  localparam upc_t A_POW_SET  = 5'd18;
  localparam upc_t A_POW_LOOP = 5'd19;
  localparam upc_t A_POW_SQ   = 5'd20;
  localparam upc_t A_WB       = 5'd21;
  localparam upc_t A_E_UNDER  = 5'd22;
  localparam upc_t A_E_OVER   = 5'd23;
  localparam upc_t A_E_DZ     = 5'd24;

  function automatic ucode_t uw(uop_t u, cond_t c, upc_t t);
    ucode_t w;
    w.uop    = u;
    w.cond   = c;
    w.target = t;
    return w;
  endfunction

  // control store: taken condition jumps to target (dispatch jumps to the token's entry), otherwise fall through
  function automatic ucode_t ucode_rom(upc_t a);
    ucode_t w;
    unique case (a)
      A_EMIT:     w = uw(U_EMIT,      C_OUTBUSY,  A_EMIT);
      A_FETCH:    w = uw(U_FETCH,     C_NOACC,    A_FETCH);
      A_DECODE:   w = uw(U_NOP,       C_DISPATCH, A_FETCH);
      A_PUSH:     w = uw(U_NOP,       C_FULL,     A_E_OVER);
      A_PUSH1:    w = uw(U_PUSH,      C_ALWAYS,   A_EMIT);
      A_FIN:      w = uw(U_NOP,       C_EMPTY,    A_E_UNDER);
      A_FIN1:     w = uw(U_FINISH,    C_ALWAYS,   A_EMIT);
      A_ADD:      w = uw(U_LOADXY,    C_LT2,      A_E_UNDER);
      A_ADD1:     w = uw(U_ADD,       C_ALWAYS,   A_WB);
      A_SUB:      w = uw(U_LOADXY,    C_LT2,      A_E_UNDER);
      A_SUB1:     w = uw(U_SUB,       C_ALWAYS,   A_WB);
      A_MUL:      w = uw(U_LOADXY,    C_LT2,      A_E_UNDER);
      A_MUL1:     w = uw(U_MUL,       C_ALWAYS,   A_WB);
      A_DIV:      w = uw(U_LOADXY,    C_LT2,      A_E_UNDER);
      A_DIV_SET:  w = uw(U_DIV_SETUP, C_YZERO,    A_E_DZ);
      A_DIV_LOOP: w = uw(U_DIV_STEP,  C_MORE,     A_DIV_LOOP);
      A_DIV_FIN:  w = uw(U_DIV_FIN,   C_ALWAYS,   A_WB);
      A_POW:      w = uw(U_LOADXY,    C_LT2,      A_E_UNDER);
      A_POW_SET:  w = uw(U_POW_SETUP, C_YNEG,     A_WB);
      A_POW_LOOP: w = uw(U_POW_MUL,   C_YZERO,    A_WB);
      A_POW_SQ:   w = uw(U_POW_SQ,    C_ALWAYS,   A_POW_LOOP);
      A_WB:       w = uw(U_WB,        C_ALWAYS,   A_EMIT);
      A_E_UNDER:  w = uw(U_ERR_UNDER, C_ALWAYS,   A_EMIT);
      A_E_OVER:   w = uw(U_ERR_OVER,  C_ALWAYS,   A_EMIT);
      A_E_DZ:     w = uw(U_ERR_DZ,    C_ALWAYS,   A_EMIT);
      default:    w = uw(U_NOP,       C_ALWAYS,   A_FETCH);
    endcase
    return w;
  endfunction

  // entry point of each token's routine
  function automatic upc_t entry_of(op_t op);
    upc_t a;
    unique case (op)
      OP_PUSH:   a = A_PUSH;
      OP_ADD:    a = A_ADD;
      OP_SUB:    a = A_SUB;
      OP_MUL:    a = A_MUL;
      OP_DIV:    a = A_DIV;
      OP_MOD:    a = A_DIV;
      OP_POW:    a = A_POW;
      OP_FINISH: a = A_FIN;
    endcase
    return a;
  endfunction

endpackage

[hdl/pse_in_if.sv]
// token channel: valid/ready with op and digit
`timescale 1ns / 1ps

interface pse_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [3:0] digit;

  modport source (output valid, output op, output digit, input ready);
  modport sink (input valid, input op, input digit, output ready);
endinterface

[hdl/pse_out_if.sv]
// result channel: valid/ready with value, depth, error and finish flag
`timescale 1ns / 1ps

interface pse_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] top_value;
  logic        [4:0]  stack_depth;
  logic        [1:0]  error_code;
  logic               final_result;

  modport source (output valid, output top_value, output stack_depth,
                  output error_code, output final_result, input ready);
  modport sink (input valid, input top_value, input stack_depth,
                input error_code, input final_result, output ready);
endinterface

[hdl/postfix_stack_evaluator.sv]
// top level of the microcoded postfix expression evaluator
`timescale 1ns / 1ps

// postfix expression evaluator: takes one token per item (push a digit, a
// binary operator or finish) and returns one result item per token with the
// new top of stack, the depth, an error code and a finish flag. the stack
// holds STACK_DEPTH words of WORD_BITS bits in a single-port-write memory;
// a shadow register keeps the top word so that an operator needs one read.
// control is a microprogram of about two dozen words stepped by a program
// counter. divide and mod take one quotient bit per cycle of the divide loop;
// power does one multiply and one squaring on the shared multiplier per bit
// of a non-negative exponent, and a negative exponent skips the loop.
// one token is in flight at a time; the next token is taken as soon as the
// result has been loaded into the output register, even while that result
// still waits to be taken.
// no clearing pass is needed after reset: the stack is empty and only
// written entries are ever read.

module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = 16,
  parameter int WORD_BITS   = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  pse_in_if.sink   in_ch,
  pse_out_if.source out_ch
);
  import pse_pkg::*;

  localparam int SPW = $clog2(STACK_DEPTH + 1);

  uop_t                 uop;
  flags_t               flags;
  logic                 accept;
  logic                 out_busy;
  logic                 emit;
  logic [WORD_BITS-1:0] dp_top;
  logic [SPW-1:0]       dp_sp;
  err_t                 dp_err;
  logic                 dp_fin;
  logic [WORD_BITS-1:0] shown;
  logic signed [31:0]   shown_ext;
  logic [31:0]          sp_ext;

  logic                 out_valid_r;
  logic signed [15:0]   out_top_r;
  logic [4:0]           out_depth_r;
  logic [1:0]           out_err_r;
  logic                 out_fin_r;

  // ready only while the microprogram waits at fetch
  assign in_ch.ready = (uop == U_FETCH);
  assign accept      = in_ch.valid & in_ch.ready;

  // output slot is busy while a result waits and is not taken this cycle
  assign out_busy = out_valid_r & ~out_ch.ready;
  assign emit     = (uop == U_EMIT) & ~out_busy;

  pse_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .out_busy (out_busy),
    .flags    (flags),
    .uop      (uop)
  );

  pse_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .WORD_BITS   (WORD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .uop      (uop),
    .accept   (accept),
    .in_op    (in_ch.op),
    .in_digit (in_ch.digit),
    .flags    (flags),
    .top_word (dp_top),
    .depth    (dp_sp),
    .err      (dp_err),
    .fin      (dp_fin)
  );

  // a finish shows the popped top, an empty stack shows zero
  assign shown     = (dp_fin || (dp_sp != '0)) ? dp_top : '0;
  assign shown_ext = 32'(signed'(shown));
  assign sp_ext    = 32'(dp_sp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded once per item
  always_ff @(posedge clk) begin
    if (emit) begin
      out_top_r   <= shown_ext[15:0];
      out_depth_r <= sp_ext[4:0];
      out_err_r   <= dp_err;
      out_fin_r   <= dp_fin;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.top_value    = out_top_r;
  assign out_ch.stack_depth  = out_depth_r;
  assign out_ch.error_code   = out_err_r;
  assign out_ch.final_result = out_fin_r;

endmodule

[hdl/pse_sequencer.sv]
// microprogram counter and control store of the postfix evaluator
`timescale 1ns / 1ps

module pse_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic            out_busy,
  input  pse_pkg::flags_t flags,
  output pse_pkg::uop_t   uop
);
  import pse_pkg::*;

  upc_t   pc_r;
  upc_t   pc_nxt;
  ucode_t word;
  logic   take;

  always_comb begin
    word = ucode_rom(pc_r);
    unique case (word.cond)
      C_ALWAYS:   take = 1'b1;
      C_NOACC:    take = !accept;
      C_OUTBUSY:  take = out_busy;
      C_DISPATCH: take = 1'b1;
      C_FULL:     take = flags.full;
      C_EMPTY:    take = flags.empty;
      C_LT2:      take = flags.lt2;
      C_YZERO:    take = flags.yzero;
      C_MORE:     take = flags.more;
      C_YNEG:     take = flags.yneg;
      default:    take = 1'b0;
    endcase
    if (!take) begin
      pc_nxt = upc_t'(pc_r + 1'b1);
    end else if (word.cond == C_DISPATCH) begin
      pc_nxt = entry_of(flags.op);
    end else begin
      pc_nxt = word.target;
    end
  end

  assign uop = word.uop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= A_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

[hdl/pse_datapath.sv]
// operand stack, working registers, shared multiplier and divide step
`timescale 1ns / 1ps

module pse_datapath #(
  parameter int STACK_DEPTH = 16,
  parameter int WORD_BITS   = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pse_pkg::uop_t                      uop,
  input  logic                               accept,
  input  logic [2:0]                         in_op,
  input  logic [3:0]                         in_digit,
  output pse_pkg::flags_t                    flags,
  output logic [WORD_BITS-1:0]               top_word,
  output logic [$clog2(STACK_DEPTH+1)-1:0]   depth,
  output pse_pkg::err_t                      err,
  output logic                               fin
);
  import pse_pkg::*;

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int CW  = $clog2(WORD_BITS + 1);
  localparam int W   = WORD_BITS;

  logic [W-1:0]   mem [STACK_DEPTH];
  logic [W-1:0]   rd_r;

  op_t            op_r;
  logic [3:0]     digit_r;
  logic [SPW-1:0] sp_r;
  err_t           err_r;
  logic           fin_r;
  logic [W-1:0]   top_r;
  logic [W-1:0]   x_r;
  logic [W-1:0]   y_r;
  logic [W-1:0]   acc_r;
  logic [CW-1:0]  cnt_r;
  logic           negq_r;
  logic           negr_r;

  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  wr_addr;
  logic           wr_en;
  logic [W-1:0]   wr_data;
  logic [W-1:0]   mul_a;
  logic [W-1:0]   mul_b;
  logic [2*W-1:0] prod;
  logic [W-1:0]   mul_lo;
  logic [W:0]     trial;
  logic [W-1:0]   x_abs;
  logic [W-1:0]   y_abs;
  logic [W-1:0]   pow_neg;

  // second entry from the top, read every cycle
  assign rd_addr = AW'(sp_r - SPW'(2));
  assign wr_en   = (uop == U_PUSH) || (uop == U_WB);
  assign wr_addr = (uop == U_PUSH) ? sp_r[AW-1:0] : rd_addr;
  assign wr_data = (uop == U_PUSH) ? W'(digit_r) : acc_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[rd_addr];
  end

  // one multiplier shared by multiply and power
  always_comb begin
    unique case (uop)
      U_POW_MUL: begin
        mul_a = acc_r;
        mul_b = x_r;
      end
      U_POW_SQ: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      default: begin
        mul_a = x_r;
        mul_b = y_r;
      end
    endcase
  end
  assign prod   = mul_a * mul_b;
  assign mul_lo = prod[W-1:0];

  // restoring divide, one quotient bit a step
  assign trial = {acc_r, x_r[W-1]} - {1'b0, y_r};
  assign x_abs = x_r[W-1] ? -x_r : x_r;
  assign y_abs = y_r[W-1] ? -y_r : y_r;

  // negative exponent: only a base of plus or minus one survives
  always_comb begin
    if (x_r == W'(1)) begin
      pow_neg = W'(1);
    end else if (x_r == {W{1'b1}}) begin
      pow_neg = y_r[0] ? {W{1'b1}} : W'(1);
    end else begin
      pow_neg = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r  <= '0;
      err_r <= ERR_OK;
      fin_r <= 1'b0;
    end else begin
      unique case (uop)
        U_FETCH: begin
          if (accept) begin
            err_r <= ERR_OK;
            fin_r <= 1'b0;
          end
        end
        U_PUSH:      sp_r  <= sp_r + 1'b1;
        U_FINISH: begin
          sp_r  <= '0;
          fin_r <= 1'b1;
        end
        U_WB:        sp_r  <= sp_r - 1'b1;
        U_ERR_UNDER: err_r <= ERR_UNDER;
        U_ERR_OVER:  err_r <= ERR_OVER;
        U_ERR_DZ:    err_r <= ERR_DIVZERO;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (uop)
      U_FETCH: begin
        if (accept) begin
          op_r    <= op_t'(in_op);
          digit_r <= in_digit;
        end
      end
      U_PUSH:  top_r <= W'(digit_r);
      U_LOADXY: begin
        x_r <= rd_r;
        y_r <= top_r;
      end
      U_ADD:   acc_r <= x_r + y_r;
      U_SUB:   acc_r <= x_r - y_r;
      U_MUL:   acc_r <= mul_lo;
      U_DIV_SETUP: begin
        x_r    <= x_abs;
        y_r    <= y_abs;
        acc_r  <= '0;
        cnt_r  <= CW'(W);
        negq_r <= x_r[W-1] ^ y_r[W-1];
        negr_r <= x_r[W-1];
      end
      U_DIV_STEP: begin
        acc_r <= trial[W] ? {acc_r[W-2:0], x_r[W-1]} : trial[W-1:0];
        x_r   <= {x_r[W-2:0], ~trial[W]};
        cnt_r <= cnt_r - 1'b1;
      end
      U_DIV_FIN: begin
        if (op_r == OP_MOD) begin
          acc_r <= negr_r ? -acc_r : acc_r;
        end else begin
          acc_r <= negq_r ? -x_r : x_r;
        end
      end
      U_POW_SETUP: acc_r <= y_r[W-1] ? pow_neg : W'(1);
      U_POW_MUL: begin
        if (y_r[0]) begin
          acc_r <= mul_lo;
        end
      end
      U_POW_SQ: begin
        x_r <= mul_lo;
        y_r <= y_r >> 1;
      end
      U_WB:    top_r <= acc_r;
      default: ;
    endcase
  end

  always_comb begin
    flags.op    = op_r;
    flags.full  = (sp_r == SPW'(STACK_DEPTH));
    flags.empty = (sp_r == '0);
    flags.lt2   = (sp_r < SPW'(2));
    flags.yzero = (y_r == '0);
    flags.more  = (cnt_r != CW'(1));
    flags.yneg  = y_r[W-1];
  end

  assign top_word = top_r;
  assign depth    = sp_r;
  assign err      = err_r;
  assign fin      = fin_r;

endmodule

[hdl/pse_checker.sv]
// port-level checks of the postfix evaluator and their binding
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pse_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_top_value,
  input logic [4:0]  out_stack_depth,
  input logic [1:0]  out_error_code,
  input logic        out_final_result
);
  import pse_pkg::*;

  // a stalled result stays put
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_top_value) && $stable(out_stack_depth) && $stable(out_error_code) && $stable(out_final_result))

  // one token at a time: ready drops right after an item is taken
  `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

  // no result can appear in the cycle right after a token is taken
  `ASSERT_NEXT(a_no_early_result, clk, rst_n, in_valid && in_ready, !$rose(out_valid))

  // a finish result is error-free and leaves an empty stack
  `ASSERT_SAME(a_finish_clean, clk, rst_n, out_valid && out_final_result, out_error_code == ERR_OK && out_stack_depth == 5'd0)

endmodule

bind postfix_stack_evaluator pse_props u_pse_props (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_top_value    (out_ch.top_value),
  .out_stack_depth  (out_ch.stack_depth),
  .out_error_code   (out_ch.error_code),
  .out_final_result (out_ch.final_result)
);
